### sv/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg: shared types and constants for the blocked record deframer
// Word layout, control word types, result kinds and the result beat struct.
// ----------------------------------------------------------------------------
package brd_pkg;

  // Stream framing
  localparam int BLOCK_WORDS = 512;
  localparam int BLK_CNT_W   = $clog2(BLOCK_WORDS + 1);

  // Field widths
  localparam int WORD_W   = 64;
  localparam int LEN_W    = 16;
  localparam int FWI_W    = 9;
  localparam int UBITS_W  = 6;
  localparam int TYPE_W   = 4;
  localparam int KIND_W   = 3;

  // Control word bit positions
  localparam int TYPE_LSB  = 60;
  localparam int UBITS_LSB = 54;

  // Reset value of the record length limit
  localparam logic [LEN_W-1:0] MAX_REC_RESET = LEN_W'(8500);

  // Control word types
  localparam logic [TYPE_W-1:0] TYPE_BLOCK = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_EOR   = 4'd8;
  localparam logic [TYPE_W-1:0] TYPE_EOF   = 4'd14;
  localparam logic [TYPE_W-1:0] TYPE_EOD   = 4'd15;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA     = 3'd0,
    KIND_END_REC  = 3'd1,
    KIND_END_FILE = 3'd2,
    KIND_END_DATA = 3'd3,
    KIND_BAD_TYPE = 3'd4,
    KIND_TOO_LONG = 3'd5,
    KIND_OVERRUN  = 3'd6
  } kind_t;

  // One result beat
  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  data_word;
    logic [LEN_W-1:0]   record_words;
    logic [UBITS_W-1:0] unused_bits;
  } res_t;

endpackage

### sv/brd_if.sv
// ----------------------------------------------------------------------------
// brd_if: handshake channels of the blocked record deframer
// Stream input, result output and configuration write channels.
// ----------------------------------------------------------------------------

// Input stream channel
interface brd_in_if;
  logic                      valid;
  logic                      ready;
  logic [brd_pkg::WORD_W-1:0] stream_word;
  logic                      input_ended;

  modport source (output valid, output stream_word, output input_ended, input ready);
  modport sink   (input valid, input stream_word, input input_ended, output ready);
endinterface

// Result channel
interface brd_out_if;
  logic                        valid;
  logic                        ready;
  logic [brd_pkg::KIND_W-1:0]  result_kind;
  logic [brd_pkg::WORD_W-1:0]  data_word;
  logic [brd_pkg::LEN_W-1:0]   record_words;
  logic [brd_pkg::UBITS_W-1:0] unused_bits;

  modport source (output valid, output result_kind, output data_word,
                  output record_words, output unused_bits, input ready);
  modport sink   (input valid, input result_kind, input data_word,
                  input record_words, input unused_bits, output ready);
endinterface

// Configuration write channel (max_record_words)
interface brd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [brd_pkg::LEN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/brd_out_stage.sv
// ----------------------------------------------------------------------------
// brd_out_stage: result register with skid entry
// Holds up to two result beats so the input side keeps running while the
// sink stalls; ready toward the core is simply "skid entry empty".
// ----------------------------------------------------------------------------
module brd_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brd_pkg::res_t push_data,
  output logic          can_push,
  output logic          out_valid,
  output brd_pkg::res_t out_data,
  input  logic          out_ready
);
  import brd_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  // Output register refills from skid first, else straight from the core
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
          out_data  <= push_data;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

endmodule

### sv/blocked_record_deframer.sv
// ----------------------------------------------------------------------------
// blocked_record_deframer: blocked record stream reader
// Splits a stream of 64-bit words in fixed-size blocks into data words and
// record / file / data end marks, checks record length and block overrun.
//
//   channel  dir  role    payload
//   -------  ---  ------  -------------------------------------------------
//   stream   in   sink    stream_word[63:0], input_ended
//   result   out  source  result_kind[2:0], data_word[63:0],
//                         record_words[15:0], unused_bits[5:0]
//   cfg      in   sink    data[15:0] -> max_record_words
//
// One stream beat per cycle while the skid entry is empty; a beat's result
// goes to the output register, or to the skid entry if that is held. Counter
// updates and the one 17-bit add-compare set the stream-to-result path.
// Synchronous reset clears counters, the stop flag and the output stage and
// loads the record limit with 8500. A stalled sink is absorbed by one skid
// entry; stream.ready drops only while that entry is full. After an error
// beats are still taken but give no result until reset.
// ----------------------------------------------------------------------------
module blocked_record_deframer (
  input logic       clk,
  input logic       rst,
  brd_in_if.sink    stream,
  brd_out_if.source result,
  brd_cfg_if.sink   cfg
);
  import brd_pkg::*;

  localparam logic [BLK_CNT_W-1:0] BLOCK_WORDS_C = BLK_CNT_W'(BLOCK_WORDS);

  // Registers
  logic [LEN_W-1:0]     max_record_words;
  logic [FWI_W-1:0]     data_words_left, data_words_left_next;
  logic [BLK_CNT_W-1:0] block_words_left, block_words_left_next;
  logic [LEN_W-1:0]     record_length, record_length_next;
  logic                 stopped, stopped_next;

  // Core to output stage
  logic accept;
  logic push;
  res_t push_data;
  logic can_push;
  logic out_valid;
  res_t out_data;

  // Control word fields
  logic [TYPE_W-1:0]    ctl_type;
  logic [UBITS_W-1:0]   ctl_ubits;
  logic [FWI_W-1:0]     ctl_fwi;
  logic [LEN_W:0]       run_total;
  logic                 too_long;
  logic                 overrun;
  logic [BLK_CNT_W-1:0] blk_base;

  assign accept    = stream.valid && stream.ready;
  assign ctl_type  = stream.stream_word[TYPE_LSB +: TYPE_W];
  assign ctl_ubits = stream.stream_word[UBITS_LSB +: UBITS_W];
  assign ctl_fwi   = stream.stream_word[FWI_W-1:0];

  // Run checks
  assign run_total = {1'b0, record_length} + (LEN_W+1)'(data_words_left);
  assign too_long  = run_total > {1'b0, max_record_words};
  assign overrun   = LEN_W'(data_words_left) > LEN_W'(block_words_left);
  assign blk_base  = (block_words_left == '0) ? BLOCK_WORDS_C : block_words_left;

  // Per-beat decode
  always_comb begin
    data_words_left_next  = data_words_left;
    block_words_left_next = block_words_left;
    record_length_next    = record_length;
    stopped_next          = stopped;
    push                  = 1'b0;
    push_data             = '0;
    push_data.kind        = KIND_DATA;

    if (accept && !stopped) begin
      if (stream.input_ended) begin
        data_words_left_next  = '0;
        block_words_left_next = '0;
        record_length_next    = '0;
        push                  = 1'b1;
        push_data.kind        = KIND_END_DATA;
      end else if (block_words_left == '0 && data_words_left != '0) begin
        // run ran past the block end
        stopped_next   = 1'b1;
        push           = 1'b1;
        push_data.kind = KIND_OVERRUN;
      end else if (data_words_left != '0) begin
        push = 1'b1;
        if (too_long) begin
          stopped_next   = 1'b1;
          push_data.kind = KIND_TOO_LONG;
        end else if (overrun) begin
          stopped_next   = 1'b1;
          push_data.kind = KIND_OVERRUN;
        end else begin
          record_length_next    = record_length + 1'b1;
          data_words_left_next  = data_words_left - 1'b1;
          block_words_left_next = block_words_left - 1'b1;
          push_data.kind        = KIND_DATA;
          push_data.data_word   = stream.stream_word;
        end
      end else begin
        // control word
        block_words_left_next = blk_base - 1'b1;
        unique case (ctl_type)
          TYPE_BLOCK: begin
            data_words_left_next = ctl_fwi;
          end
          TYPE_EOR: begin
            data_words_left_next   = ctl_fwi;
            record_length_next     = '0;
            push                   = 1'b1;
            push_data.kind         = KIND_END_REC;
            push_data.record_words = record_length;
            push_data.unused_bits  = ctl_ubits;
          end
          TYPE_EOF: begin
            data_words_left_next = ctl_fwi;
            record_length_next   = '0;
            push                 = 1'b1;
            push_data.kind       = KIND_END_FILE;
          end
          TYPE_EOD: begin
            data_words_left_next = ctl_fwi;
            record_length_next   = '0;
            push                 = 1'b1;
            push_data.kind       = KIND_END_DATA;
          end
          default: begin
            stopped_next   = 1'b1;
            push           = 1'b1;
            push_data.kind = KIND_BAD_TYPE;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_words <= MAX_REC_RESET;
      data_words_left  <= '0;
      block_words_left <= '0;
      record_length    <= '0;
      stopped          <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        max_record_words <= cfg.data;
      end
      data_words_left  <= data_words_left_next;
      block_words_left <= block_words_left_next;
      record_length    <= record_length_next;
      stopped          <= stopped_next;
    end
  end

  // Output register and skid entry
  brd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (result.ready)
  );

  assign stream.ready        = can_push;
  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.result_kind  = out_data.kind;
  assign result.data_word    = out_data.data_word;
  assign result.record_words = out_data.record_words;
  assign result.unused_bits  = out_data.unused_bits;

  // Checks
  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_no_result_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !push)
    else $error("result produced while stopped");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> result.valid)
    else $error("input stalled with empty output register");

  a_data_counts: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.kind == KIND_DATA && !stopped)
      |=> record_length == $past(record_length) + 1'b1)
    else $error("data beat did not advance record length");

endmodule
